// ===== hdl/lgd_pkg.sv =====
// Package for the infrared lap-gate beacon decoder.
// Holds widths, codes, the configuration record and the pulse class type.
// No dependencies; every other file imports it.
package lgd_pkg;

  localparam int CODE_BITS  = 8;
  localparam int GATE_SHIFT = 2;

  localparam int CODE_W    = 8;
  localparam int CODE_IDX_W = $clog2(CODE_W);
  localparam int BIT_CNT_W = $clog2(CODE_BITS + 1);
  localparam int GATE_W    = 4;
  localparam int PERIOD_W  = 16;
  localparam int TIME_W    = 32;
  localparam int LAPS_W    = 16;
  localparam int TICKS_W   = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic FUNC_CAPTURE = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  localparam logic [1:0] MARK_PATTERN = 2'b01;

  localparam logic [LAPS_W-1:0]  LAPS_MAX  = '1;
  localparam logic [TICKS_W-1:0] TICKS_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_LOW     = 3'd0,
    REG_SHORT_HIGH    = 3'd1,
    REG_LONG_LOW      = 3'd2,
    REG_LONG_HIGH     = 3'd3,
    REG_HOLDOFF_LIMIT = 3'd4,
    REG_CHECK_START   = 3'd5,
    REG_CHECK_END     = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] short_low;
    logic [PERIOD_W-1:0] short_high;
    logic [PERIOD_W-1:0] long_low;
    logic [PERIOD_W-1:0] long_high;
    logic [TICKS_W-1:0]  holdoff_limit;
    logic                check_start;
    logic                check_end;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    short_low:     16'd150,
    short_high:    16'd350,
    long_low:      16'd350,
    long_high:     16'd650,
    holdoff_limit: 8'd10,
    check_start:   1'b0,
    check_end:     1'b0
  };

  typedef enum logic [1:0] {
    PULSE_NONE,
    PULSE_SHORT,
    PULSE_LONG
  } pulse_class_t;

endpackage

// ===== hdl/lgd_if.sv =====
// Channel interfaces for the lap-gate decoder: event input, result output
// and configuration write. Depends on lgd_pkg.
interface lgd_in_if
  import lgd_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                func;
  logic [PERIOD_W-1:0] pulse_period;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, func, pulse_period, now_ms, input ready);
  modport sink   (input valid, func, pulse_period, now_ms, output ready);
endinterface

interface lgd_out_if
  import lgd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [LAPS_W-1:0] lap_count;
  logic [TIME_W-1:0] last_lap_time;
  logic [GATE_W-1:0] gate_id;
  logic [TIME_W-1:0] gate_stamp;
  logic              lap_seen;
  logic              gate_seen;
  logic              in_holdoff;

  modport source (output valid, lap_count, last_lap_time, gate_id, gate_stamp,
                  lap_seen, gate_seen, in_holdoff, input ready);
  modport sink   (input valid, lap_count, last_lap_time, gate_id, gate_stamp,
                  lap_seen, gate_seen, in_holdoff, output ready);
endinterface

interface lgd_cfg_if
  import lgd_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// ===== hdl/lgd_pulse_class.sv =====
// Pulse period classifier: short window strict, long window lower bound
// inclusive, short tested first. Depends on lgd_pkg.
module lgd_pulse_class
  import lgd_pkg::*;
(
  input  cfg_t                cfg,
  input  logic [PERIOD_W-1:0] period,
  output pulse_class_t        pclass
);

  logic is_short;
  logic is_long;

  assign is_short = (period > cfg.short_low) && (period < cfg.short_high);
  assign is_long  = (period >= cfg.long_low) && (period < cfg.long_high);

  always_comb begin
    priority if (is_short) begin
      pclass = PULSE_SHORT;
    end else if (is_long) begin
      pclass = PULSE_LONG;
    end else begin
      pclass = PULSE_NONE;
    end
  end

endmodule

// ===== hdl/ir_pulse_code_lap_gate_decoder_core.sv =====
// Top level of the infrared lap-gate beacon decoder: configuration registers,
// input register, frame and holdoff state, result register.
// Depends on lgd_pkg, lgd_if and lgd_pulse_class.
// An accepted item loads the input register; the result register is loaded from it once
// the result register is free or being taken.
// Throughput: one item per cycle while results are taken; a stalled result register holds the input.
// Reset: synchronous, active low; clears valid flags and decoder state, loads default thresholds.
module ir_pulse_code_lap_gate_decoder_core
  import lgd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lgd_in_if.sink    in_ch,
  lgd_out_if.source out_ch,
  lgd_cfg_if.sink   cfg_ch
);

  cfg_t cfg_r;

  logic                s1_valid_r;
  logic                s1_func_r;
  logic [PERIOD_W-1:0] s1_period_r;
  logic [TIME_W-1:0]   s1_now_r;

  logic [BIT_CNT_W-1:0] bit_count_r, bit_count_nxt;
  logic [CODE_W-1:0]    code_r, code_nxt;
  logic [TICKS_W-1:0]   ticks_r, ticks_nxt;
  logic                 holdoff_r, holdoff_nxt;
  logic [LAPS_W-1:0]    laps_r, laps_nxt;
  logic [TIME_W-1:0]    lap_time_r, lap_time_nxt;
  logic [GATE_W-1:0]    gate_r, gate_nxt;
  logic [TIME_W-1:0]    gate_time_r, gate_time_nxt;
  logic                 lap_seen_nxt, gate_seen_nxt;

  logic                 out_valid_r;
  logic [LAPS_W-1:0]    out_laps_r;
  logic [TIME_W-1:0]    out_lap_time_r;
  logic [GATE_W-1:0]    out_gate_r;
  logic [TIME_W-1:0]    out_gate_time_r;
  logic                 out_lap_seen_r;
  logic                 out_gate_seen_r;
  logic                 out_holdoff_r;

  logic s1_go;
  logic in_take;

  pulse_class_t         pclass;
  logic                 frame_ok;
  logic [CODE_W-1:0]    code_shifted;
  logic [GATE_W-1:0]    gate_field;
  logic [CODE_W-1:0]    bit_mask;
  logic [CODE_W-1:0]    code_base;

  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.idx))
        REG_SHORT_LOW:     cfg_r.short_low     <= cfg_ch.data;
        REG_SHORT_HIGH:    cfg_r.short_high    <= cfg_ch.data;
        REG_LONG_LOW:      cfg_r.long_low      <= cfg_ch.data;
        REG_LONG_HIGH:     cfg_r.long_high     <= cfg_ch.data;
        REG_HOLDOFF_LIMIT: cfg_r.holdoff_limit <= cfg_ch.data[TICKS_W-1:0];
        REG_CHECK_START:   cfg_r.check_start   <= cfg_ch.data[0];
        REG_CHECK_END:     cfg_r.check_end     <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r   <= in_ch.func;
      s1_period_r <= in_ch.pulse_period;
      s1_now_r    <= in_ch.now_ms;
    end
  end

  lgd_pulse_class u_class (
    .cfg    (cfg_r),
    .period (s1_period_r),
    .pclass (pclass)
  );

  assign code_shifted = code_r >> GATE_SHIFT;
  assign gate_field   = code_shifted[GATE_W-1:0];
  assign bit_mask     = CODE_W'(1) << bit_count_r[CODE_IDX_W-1:0];
  assign code_base    = (bit_count_r == '0) ? '0 : code_r;

  assign frame_ok = (bit_count_r == BIT_CNT_W'(CODE_BITS))
                 && (!cfg_r.check_start || code_r[1:0] == MARK_PATTERN)
                 && (!cfg_r.check_end || code_r[CODE_BITS-1 -: 2] == MARK_PATTERN);

  always_comb begin
    bit_count_nxt = bit_count_r;
    code_nxt      = code_r;
    ticks_nxt     = ticks_r;
    holdoff_nxt   = holdoff_r;
    laps_nxt      = laps_r;
    lap_time_nxt  = lap_time_r;
    gate_nxt      = gate_r;
    gate_time_nxt = gate_time_r;
    lap_seen_nxt  = 1'b0;
    gate_seen_nxt = 1'b0;
    if (s1_func_r == FUNC_CAPTURE) begin
      if (!holdoff_r) begin
        if (bit_count_r >= BIT_CNT_W'(CODE_BITS)) begin
          bit_count_nxt = '0;
          code_nxt      = '0;
        end else begin
          unique case (pclass)
            PULSE_SHORT: begin
              code_nxt      = code_base & ~bit_mask;
              bit_count_nxt = bit_count_r + BIT_CNT_W'(1);
            end
            PULSE_LONG: begin
              code_nxt      = code_base | bit_mask;
              bit_count_nxt = bit_count_r + BIT_CNT_W'(1);
            end
            default: code_nxt = code_base;
          endcase
        end
      end
    end else begin
      priority if (frame_ok) begin
        ticks_nxt   = '0;
        holdoff_nxt = 1'b1;
        if (gate_field == '0) begin
          if (laps_r != LAPS_MAX) begin
            laps_nxt = laps_r + LAPS_W'(1);
          end
          lap_time_nxt = s1_now_r;
          lap_seen_nxt = 1'b1;
        end else begin
          gate_nxt      = gate_field;
          gate_time_nxt = s1_now_r;
          gate_seen_nxt = 1'b1;
        end
      end else if (ticks_r > cfg_r.holdoff_limit) begin
        ticks_nxt   = '0;
        holdoff_nxt = 1'b0;
      end else if (holdoff_r) begin
        if (ticks_r != TICKS_MAX) begin
          ticks_nxt = ticks_r + TICKS_W'(1);
        end
      end
      bit_count_nxt = '0;
      code_nxt      = '0;
    end
  end

  // decoder state, advanced once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r <= '0;
      code_r      <= '0;
      ticks_r     <= '0;
      holdoff_r   <= 1'b0;
      laps_r      <= '0;
      lap_time_r  <= '0;
      gate_r      <= '0;
      gate_time_r <= '0;
    end else if (s1_go) begin
      bit_count_r <= bit_count_nxt;
      code_r      <= code_nxt;
      ticks_r     <= ticks_nxt;
      holdoff_r   <= holdoff_nxt;
      laps_r      <= laps_nxt;
      lap_time_r  <= lap_time_nxt;
      gate_r      <= gate_nxt;
      gate_time_r <= gate_time_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_laps_r      <= laps_nxt;
      out_lap_time_r  <= lap_time_nxt;
      out_gate_r      <= gate_nxt;
      out_gate_time_r <= gate_time_nxt;
      out_lap_seen_r  <= lap_seen_nxt;
      out_gate_seen_r <= gate_seen_nxt;
      out_holdoff_r   <= holdoff_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.lap_count     = out_laps_r;
  assign out_ch.last_lap_time = out_lap_time_r;
  assign out_ch.gate_id       = out_gate_r;
  assign out_ch.gate_stamp    = out_gate_time_r;
  assign out_ch.lap_seen      = out_lap_seen_r;
  assign out_ch.gate_seen     = out_gate_seen_r;
  assign out_ch.in_holdoff    = out_holdoff_r;

  a_seen_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_lap_seen_r && out_gate_seen_r))
    else $error("lap and gate reported for one item");

  a_seen_enters_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_lap_seen_r || out_gate_seen_r)) |-> out_holdoff_r)
    else $error("beacon without holdoff");

  a_bit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= BIT_CNT_W'(CODE_BITS))
    else $error("bit count beyond code length");

  a_laps_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> laps_r >= $past(laps_r))
    else $error("lap count decreased");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ir_pulse_code_lap_gate_decoder_core: pulse and tick items in,
// beacon reports out, each checked field by field against a built-in decoder model
// or a typed row's fixed result. Depends on lgd_pkg and the channel interfaces of lgd_if.
module testbench;
  import lgd_pkg::*;

  typedef struct packed {
    logic [LAPS_W-1:0] lap_count;
    logic [TIME_W-1:0] last_lap_time;
    logic [GATE_W-1:0] gate_id;
    logic [TIME_W-1:0] gate_stamp;
    logic              lap_seen;
    logic              gate_seen;
    logic              in_holdoff;
  } beacon_res_t;

  typedef struct packed {
    logic                func;
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   now;
    logic                typed;
    beacon_res_t         want;
  } stim_row_t;

  localparam beacon_res_t RES_IDLE = '0;
  localparam beacon_res_t RES_GATE_F = '{lap_count: '0, last_lap_time: '0, gate_id: 4'hF,
                                         gate_stamp: 32'hFFFF_FFFF, lap_seen: 1'b0,
                                         gate_seen: 1'b1, in_holdoff: 1'b1};
  localparam beacon_res_t RES_HELD_F = '{lap_count: '0, last_lap_time: '0, gate_id: 4'hF,
                                         gate_stamp: 32'hFFFF_FFFF, lap_seen: 1'b0,
                                         gate_seen: 1'b0, in_holdoff: 1'b1};

  localparam int N_ROWS = 20;
  localparam stim_row_t DIR_ROWS [N_ROWS] = '{
    '{FUNC_CAPTURE, 16'd0,     32'h0000_0000, 1'b1, RES_IDLE},
    '{FUNC_CAPTURE, 16'd150,   32'h0000_0001, 1'b1, RES_IDLE},
    '{FUNC_CAPTURE, 16'd151,   32'h8000_0000, 1'b0, RES_IDLE},
    '{FUNC_CAPTURE, 16'd349,   32'h5555_5555, 1'b0, RES_IDLE},
    '{FUNC_CAPTURE, 16'd350,   32'hAAAA_AAAA, 1'b0, RES_IDLE},
    '{FUNC_CAPTURE, 16'd649,   32'h0F0F_0F0F, 1'b0, RES_IDLE},
    '{FUNC_CAPTURE, 16'd650,   32'hF0F0_F0F0, 1'b1, RES_IDLE},
    '{FUNC_CAPTURE, 16'hFFFF,  32'hFFFF_FFFF, 1'b1, RES_IDLE},
    '{FUNC_TICK,    16'h0000,  32'h0000_0000, 1'b1, RES_IDLE},
    '{FUNC_CAPTURE, 16'd200,   32'h0000_0010, 1'b0, RES_IDLE},
    '{FUNC_CAPTURE, 16'd200,   32'h0000_0020, 1'b0, RES_IDLE},
    '{FUNC_CAPTURE, 16'd500,   32'h0000_0030, 1'b0, RES_IDLE},
    '{FUNC_CAPTURE, 16'd500,   32'h0000_0040, 1'b0, RES_IDLE},
    '{FUNC_CAPTURE, 16'd500,   32'h0000_0050, 1'b0, RES_IDLE},
    '{FUNC_CAPTURE, 16'd500,   32'h0000_0060, 1'b0, RES_IDLE},
    '{FUNC_CAPTURE, 16'd200,   32'h0000_0070, 1'b0, RES_IDLE},
    '{FUNC_CAPTURE, 16'd200,   32'h0000_0080, 1'b0, RES_IDLE},
    '{FUNC_TICK,    16'hFFFF,  32'hFFFF_FFFF, 1'b1, RES_GATE_F},
    '{FUNC_CAPTURE, 16'd500,   32'h1234_5678, 1'b1, RES_HELD_F},
    '{FUNC_TICK,    16'h0000,  32'h0000_0000, 1'b0, RES_IDLE}
  };

  logic clk = 1'b0;
  logic rst_n;

  lgd_in_if  in_ch();
  lgd_out_if out_ch();
  lgd_cfg_if cfg_ch();

  ir_pulse_code_lap_gate_decoder_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cfg_t                   cur_cfg    = CFG_RESET;
  logic [BIT_CNT_W-1:0]   bits_held  = '0;
  logic [CODE_W-1:0]      code_acc   = '0;
  logic [TICKS_W-1:0]     hold_ticks = '0;
  logic                   holding    = 1'b0;
  logic [LAPS_W-1:0]      lap_total  = '0;
  logic [TIME_W-1:0]      lap_stamp  = '0;
  logic [GATE_W-1:0]      gate_num   = '0;
  logic [TIME_W-1:0]      gate_time  = '0;

  beacon_res_t pending_reports [$];
  int unsigned events_sent;
  int unsigned reports_taken;
  int unsigned mismatches;
  bit          gaps_on;
  bit          tx_quiet;

  function automatic beacon_res_t decode_event(input logic f, input logic [PERIOD_W-1:0] p,
                                               input logic [TIME_W-1:0] t);
    beacon_res_t r;
    logic [GATE_W-1:0] gate;
    logic frame_ok;
    r = '0;
    if (f == FUNC_CAPTURE) begin
      if (!holding) begin
        if (bits_held >= CODE_BITS) begin
          bits_held = '0;
          code_acc  = '0;
        end else begin
          if (bits_held == 0) code_acc = '0;
          if (p > cur_cfg.short_low && p < cur_cfg.short_high) begin
            code_acc[bits_held] = 1'b0;
            bits_held = bits_held + 1'b1;
          end else if (p >= cur_cfg.long_low && p < cur_cfg.long_high) begin
            code_acc[bits_held] = 1'b1;
            bits_held = bits_held + 1'b1;
          end
        end
      end
    end else begin
      frame_ok = (bits_held == CODE_BITS) &&
                 (!cur_cfg.check_start || code_acc[1:0] == MARK_PATTERN) &&
                 (!cur_cfg.check_end || code_acc[CODE_BITS-1 -: 2] == MARK_PATTERN);
      gate = code_acc[GATE_SHIFT +: GATE_W];
      if (frame_ok) begin
        hold_ticks = '0;
        if (gate == '0) begin
          if (lap_total != LAPS_MAX) lap_total = lap_total + 1'b1;
          lap_stamp  = t;
          r.lap_seen = 1'b1;
        end else begin
          gate_num    = gate;
          gate_time   = t;
          r.gate_seen = 1'b1;
        end
        holding = 1'b1;
      end else if (hold_ticks > cur_cfg.holdoff_limit) begin
        hold_ticks = '0;
        holding    = 1'b0;
      end else if (holding) begin
        if (hold_ticks != TICKS_MAX) hold_ticks = hold_ticks + 1'b1;
      end
      bits_held = '0;
      code_acc  = '0;
    end
    r.lap_count     = lap_total;
    r.last_lap_time = lap_stamp;
    r.gate_id       = gate_num;
    r.gate_stamp    = gate_time;
    r.in_holdoff    = holding;
    return r;
  endfunction

  function automatic logic [PERIOD_W-1:0] bit_period(input logic one);
    int unsigned lo, hi;
    if (one) begin
      lo = cur_cfg.long_low;
      hi = cur_cfg.long_high;
    end else begin
      lo = cur_cfg.short_low + 1;
      hi = cur_cfg.short_high;
    end
    if (hi > lo) return $urandom_range(lo, hi - 1);
    return $urandom;
  endfunction

  function automatic logic [PERIOD_W-1:0] stray_period();
    case ($urandom_range(0, 4))
      0: return cur_cfg.short_low;
      1: return cur_cfg.short_high;
      2: return cur_cfg.long_low - 1'b1;
      3: return cur_cfg.long_high;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_event(input logic f, input logic [PERIOD_W-1:0] p,
                            input logic [TIME_W-1:0] t, input bit typed = 1'b0,
                            input beacon_res_t want = '0);
    beacon_res_t predicted;
    if (events_sent % 40 == 0) tx_quiet = ($urandom_range(0, 2) == 0);
    if (gaps_on && !tx_quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= f;
    in_ch.pulse_period <= p;
    in_ch.now_ms       <= t;
    do @(posedge clk); while (!in_ch.ready);
    predicted = decode_event(f, p, t);
    pending_reports.push_back(typed ? want : predicted);
    events_sent++;
  endtask

  task automatic write_reg(input cfg_idx_t r, input logic [CFG_DATA_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= r;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    case (r)
      REG_SHORT_LOW:     cur_cfg.short_low     = v;
      REG_SHORT_HIGH:    cur_cfg.short_high    = v;
      REG_LONG_LOW:      cur_cfg.long_low      = v;
      REG_LONG_HIGH:     cur_cfg.long_high     = v;
      REG_HOLDOFF_LIMIT: cur_cfg.holdoff_limit = v[TICKS_W-1:0];
      REG_CHECK_START:   cur_cfg.check_start   = v[0];
      REG_CHECK_END:     cur_cfg.check_end     = v[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input cfg_t c);
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_SHORT_LOW, c.short_low);
    write_reg(REG_SHORT_HIGH, c.short_high);
    write_reg(REG_LONG_LOW, c.long_low);
    write_reg(REG_LONG_HIGH, c.long_high);
    write_reg(REG_HOLDOFF_LIMIT, c.holdoff_limit);
    write_reg(REG_CHECK_START, c.check_start);
    write_reg(REG_CHECK_END, c.check_end);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_frame();
    logic [CODE_W-1:0] code;
    int unsigned n_bits;
    code = $urandom;
    if ($urandom_range(0, 2) == 0) code[GATE_SHIFT +: GATE_W] = '0;
    if (cur_cfg.check_start && $urandom_range(0, 4) != 0) code[1:0] = MARK_PATTERN;
    if (cur_cfg.check_end && $urandom_range(0, 4) != 0) code[CODE_BITS-1 -: 2] = MARK_PATTERN;
    n_bits = ($urandom_range(0, 5) == 0) ? $urandom_range(0, CODE_BITS + 1) : CODE_BITS;
    for (int i = 0; i < n_bits; i++) begin
      if ($urandom_range(0, 11) == 0) send_event(FUNC_CAPTURE, stray_period(), $urandom);
      send_event(FUNC_CAPTURE, bit_period(code[i % CODE_BITS]), $urandom);
    end
    send_event(FUNC_TICK, $urandom, $urandom);
    while (holding)
      send_event(($urandom_range(0, 3) == 0) ? FUNC_CAPTURE : FUNC_TICK, $urandom, $urandom);
  endtask

  task automatic send_lap(input bit drain);
    repeat (CODE_BITS) send_event(FUNC_CAPTURE, bit_period(1'b0), $urandom);
    send_event(FUNC_TICK, $urandom, $urandom);
    if (drain) begin
      while (holding) send_event(FUNC_TICK, $urandom, $urandom);
    end
  endtask

  task automatic run_phase(input int unsigned n);
    int unsigned stop_at;
    stop_at = events_sent + n;
    while (events_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) send_event($urandom_range(0, 1), $urandom, $urandom);
      else send_frame();
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : report_check
    beacon_res_t want;
    if (out_ch.valid && out_ch.ready) begin
      reports_taken++;
      if (pending_reports.size() == 0) begin
        $display("%0t: report with none expected, expected nothing got lap_count %0h",
                 $time, out_ch.lap_count);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("lap_count", want.lap_count, out_ch.lap_count);
        check_field("last_lap_time", want.last_lap_time, out_ch.last_lap_time);
        check_field("gate_id", want.gate_id, out_ch.gate_id);
        check_field("gate_stamp", want.gate_stamp, out_ch.gate_stamp);
        check_field("lap_seen", want.lap_seen, out_ch.lap_seen);
        check_field("gate_seen", want.gate_seen, out_ch.gate_seen);
        check_field("in_holdoff", want.in_holdoff, out_ch.in_holdoff);
      end
    end
  end

  initial begin : report_sink
    int unsigned cycle_no;
    bit rx_quiet;
    bit long_hold_done;
    cycle_no       = 0;
    rx_quiet       = 1'b0;
    long_hold_done = 1'b0;
    out_ch.ready   = 1'b0;
    @(posedge clk);
    forever begin
      cycle_no++;
      if (cycle_no % 50 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
      if (!long_hold_done && reports_taken >= 200) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (gaps_on && !rx_quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    cfg_t plan;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_CAPTURE;
    in_ch.pulse_period = '0;
    in_ch.now_ms       = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.idx         = '0;
    cfg_ch.data        = '0;
    gaps_on            = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++)
      send_event(DIR_ROWS[i].func, DIR_ROWS[i].period, DIR_ROWS[i].now,
                 DIR_ROWS[i].typed, DIR_ROWS[i].want);

    plan = '{short_low: 16'd100, short_high: 16'd300, long_low: 16'd300, long_high: 16'd700,
             holdoff_limit: 8'd3, check_start: 1'b1, check_end: 1'b0};
    program_regs(plan);
    run_phase(260);

    plan = '{short_low: 16'h0000, short_high: 16'hFFFF, long_low: 16'h0000,
             long_high: 16'hFFFF, holdoff_limit: 8'd0, check_start: 1'b0, check_end: 1'b1};
    program_regs(plan);
    run_phase(260);

    plan = '{short_low: 16'hFFFF, short_high: 16'h0000, long_low: 16'd1000,
             long_high: 16'd2000, holdoff_limit: 8'd12, check_start: 1'b1, check_end: 1'b1};
    program_regs(plan);
    run_phase(260);

    plan.short_low     = $urandom_range(0, 3000);
    plan.short_high    = plan.short_low + $urandom_range(0, 3000);
    plan.long_low      = $urandom_range(0, 6000);
    plan.long_high     = plan.long_low + $urandom_range(0, 6000);
    plan.holdoff_limit = $urandom_range(0, 20);
    plan.check_start   = $urandom_range(0, 1);
    plan.check_end     = $urandom_range(0, 1);
    program_regs(plan);
    run_phase(260);

    gaps_on = 1'b0;
    plan = CFG_RESET;
    plan.holdoff_limit = TICKS_MAX;
    program_regs(plan);
    send_lap(1'b0);
    repeat (300)
      send_event(($urandom_range(0, 9) == 0) ? FUNC_CAPTURE : FUNC_TICK, $urandom, $urandom);
    plan.holdoff_limit = TICKS_MAX - 1'b1;
    program_regs(plan);
    send_event(FUNC_TICK, $urandom, $urandom);

    plan.holdoff_limit = '0;
    program_regs(plan);
    repeat (3) send_lap(1'b1);

    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'd4_000_000 * 20);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lgd_pkg.sv
hdl/lgd_if.sv
hdl/lgd_pulse_class.sv
hdl/ir_pulse_code_lap_gate_decoder_core.sv
bench/testbench.sv
